// ===== hdl/nrt_pkg.sv =====
// Name registry table package: status and opcode codes, field widths.
// No dependencies; imported by every module of the name registry table.
package nrt_pkg;

   localparam int WORD_W    = 64;
   localparam int OP_W      = 2;
   localparam int IN_LEN_W  = 8;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 12;

   localparam logic [OP_W-1:0] OP_REGISTER = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_BAD_ARG   = 3'd1;
   localparam logic [STATUS_W-1:0] STS_EXISTS    = 3'd2;
   localparam logic [STATUS_W-1:0] STS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] STS_BAD_OP    = 3'd5;

   localparam logic [SLOT_W-1:0] SLOT_BASE_RST = 12'd32;

endpackage

// ===== hdl/nrt_store.sv =====
// Entry memory of the name registry table: masked name and length per entry.
// One write port, one read port with registered read data. Uses nrt_pkg.
module nrt_store #(
   parameter int DEPTH  = 32,
   parameter int IDX_W  = 5,
   parameter int NAME_W = 256,
   parameter int LEN_W  = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [NAME_W-1:0] wr_name,
   input  logic [LEN_W-1:0]  wr_len,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [NAME_W-1:0] rd_name,
   output logic [LEN_W-1:0]  rd_len
);
   import nrt_pkg::*;

   logic [LEN_W+NAME_W-1:0] mem [DEPTH];
   logic [LEN_W+NAME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_len, wr_name};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_name = rd_data_ff[NAME_W-1:0];
   assign rd_len  = rd_data_ff[LEN_W+NAME_W-1:NAME_W];

endmodule

// ===== hdl/nrt_seq.sv =====
// Request sequencer of the name registry table: entry scan, append, result register.
// Drives nrt_store read and write ports. Uses nrt_pkg.
module nrt_seq #(
   parameter int DEPTH  = 32,
   parameter int IDX_W  = 5,
   parameter int CNT_W  = 6,
   parameter int NAME_W = 256,
   parameter int LEN_W  = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [nrt_pkg::OP_W-1:0]      req_op,
   input  logic [NAME_W-1:0]             req_key,
   input  logic [LEN_W-1:0]              req_len,
   input  logic [nrt_pkg::SLOT_W-1:0]    slot_base,
   output logic                          rd_en,
   output logic [IDX_W-1:0]              rd_addr,
   input  logic [NAME_W-1:0]             rd_name,
   input  logic [LEN_W-1:0]              rd_len,
   output logic                          wr_en,
   output logic [IDX_W-1:0]              wr_addr,
   output logic [NAME_W-1:0]             wr_name,
   output logic [LEN_W-1:0]              wr_len,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nrt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [nrt_pkg::SLOT_W-1:0]    rsp_endpoint_slot
);
   import nrt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [NAME_W-1:0]   key_ff, key_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                accept;
   logic                hit;
   logic                scan_end;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign hit       = cmp_vld_ff && (rd_len == len_ff) && (rd_name == key_ff);
   assign scan_end  = hit || (!cmp_vld_ff && (rd_idx_ff == cnt_ff));
   assign rd_en     = (state_ff == ST_SCAN) && !scan_end && (rd_idx_ff != cnt_ff);
   assign rd_addr   = rd_idx_ff[IDX_W-1:0];
   assign wr_addr   = cnt_ff[IDX_W-1:0];
   assign wr_name   = key_ff;
   assign wr_len    = len_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_vld_in    = rd_en;
      cmp_idx_in    = rd_addr;
      op_in         = op_ff;
      key_in        = key_ff;
      len_in        = len_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      wr_en         = 1'b0;
      if (rd_en) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_op;
               key_in      = req_key;
               len_in      = req_len;
               rd_idx_in   = '0;
               res_slot_in = '0;
               if (req_op != OP_REGISTER && req_op != OP_LOOKUP) begin
                  res_status_in = STS_BAD_OP;
                  state_in      = ST_DONE;
               end else if (req_len == '0) begin
                  res_status_in = STS_BAD_ARG;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DONE;
               if (op_ff == OP_LOOKUP) begin
                  if (hit) begin
                     res_status_in = STS_OK;
                     res_slot_in   = slot_base + SLOT_W'(cmp_idx_ff);
                  end else begin
                     res_status_in = STS_NOT_FOUND;
                  end
               end else if (hit) begin
                  res_status_in = STS_EXISTS;
               end else if (cnt_ff == CNT_W'(DEPTH)) begin
                  res_status_in = STS_FULL;
               end else begin
                  wr_en         = 1'b1;
                  cnt_in        = cnt_ff + CNT_W'(1);
                  res_status_in = STS_OK;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff    <= cmp_idx_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      len_ff        <= len_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_endpoint_slot = rsp_slot_ff;

endmodule

// ===== hdl/name_registry_table.sv =====
// Name registry table top level: name masking, slot base register, sequencer and memory.
// Instantiates nrt_seq and nrt_store; uses nrt_pkg.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   req     | req_valid/ready, opcode, length,     | in
//           | name_word0..3                       |
//   rsp     | rsp_valid/ready, status, slot       | out
//   csr     | csr_wr_en, csr_wr_data (slot base)  | in
//
// A register or lookup scans the stored entries one per cycle through the single
// memory read port, ending early on a match; an append is written as the scan ends.
// Invalid opcode and empty name skip the scan. One item at a time; a new item is taken
// while the previous result waits in the output register, and its own result waits
// until that register is free.
// Reset empties the table and sets the slot base to 32; no clearing pass.
module name_registry_table #(
   parameter int MAX_ENTRIES    = 32,
   parameter int MAX_NAME_BYTES = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [nrt_pkg::OP_W-1:0]      req_opcode,
   input  logic [nrt_pkg::IN_LEN_W-1:0]  req_name_length,
   input  logic [nrt_pkg::WORD_W-1:0]    req_name_word0,
   input  logic [nrt_pkg::WORD_W-1:0]    req_name_word1,
   input  logic [nrt_pkg::WORD_W-1:0]    req_name_word2,
   input  logic [nrt_pkg::WORD_W-1:0]    req_name_word3,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nrt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [nrt_pkg::SLOT_W-1:0]    rsp_endpoint_slot,
   input  logic                          csr_wr_en,
   input  logic [nrt_pkg::SLOT_W-1:0]    csr_wr_data
);
   import nrt_pkg::*;

   localparam int NAME_W = 8 * MAX_NAME_BYTES;
   localparam int LEN_W  = $clog2(MAX_NAME_BYTES + 1);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic [SLOT_W-1:0]   slot_base_ff;
   logic [4*WORD_W-1:0] name_all;
   logic [NAME_W-1:0]   key;
   logic [LEN_W-1:0]    key_len;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [NAME_W-1:0]   rd_name;
   logic [LEN_W-1:0]    rd_len;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [NAME_W-1:0]   wr_name;
   logic [LEN_W-1:0]    wr_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_base_ff <= SLOT_BASE_RST;
      end else if (csr_wr_en) begin
         slot_base_ff <= csr_wr_data;
      end
   end

   // clamp length, zero the bytes past it
   assign name_all = {req_name_word3, req_name_word2, req_name_word1, req_name_word0};
   assign key_len  = (req_name_length > IN_LEN_W'(MAX_NAME_BYTES)) ?
                     LEN_W'(MAX_NAME_BYTES) : req_name_length[LEN_W-1:0];

   always_comb begin
      for (int b = 0; b < MAX_NAME_BYTES; b++) begin
         key[8*b +: 8] = (LEN_W'(b) < key_len) ? name_all[8*b +: 8] : 8'd0;
      end
   end

   nrt_seq #(
      .DEPTH  (MAX_ENTRIES),
      .IDX_W  (IDX_W),
      .CNT_W  (CNT_W),
      .NAME_W (NAME_W),
      .LEN_W  (LEN_W)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_opcode),
      .req_key           (key),
      .req_len           (key_len),
      .slot_base         (slot_base_ff),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_name           (rd_name),
      .rd_len            (rd_len),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_name           (wr_name),
      .wr_len            (wr_len),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_endpoint_slot (rsp_endpoint_slot)
   );

   nrt_store #(
      .DEPTH  (MAX_ENTRIES),
      .IDX_W  (IDX_W),
      .NAME_W (NAME_W),
      .LEN_W  (LEN_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_name (wr_name),
      .wr_len  (wr_len),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_name (rd_name),
      .rd_len  (rd_len)
   );

endmodule

// ===== test/tb_name_registry_table.sv =====
// Testbench for name_registry_table: directed and random register, lookup and bad-opcode
// items with random idling on both channels, checked against an in-bench table predictor.
// Depends on nrt_pkg and name_registry_table.
module tb_name_registry_table;
   timeunit 1ns;
   timeprecision 1ps;

   import nrt_pkg::*;

   localparam int MAX_ENTRIES    = 32;
   localparam int MAX_NAME_BYTES = 32;
   localparam int IDLE_PCT       = 36;
   localparam int STALL_LIMIT    = 2000;
   localparam int PHASE_ITEMS    = 190;
   localparam int PHASES         = 5;

   localparam logic [OP_W-1:0] OP_UNUSED_LO = 2'd0;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 2'd3;

   typedef logic [8*MAX_NAME_BYTES-1:0] name_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_opcode = '0;
   logic [IN_LEN_W-1:0] req_name_length = '0;
   logic [WORD_W-1:0]   req_name_word0 = '0;
   logic [WORD_W-1:0]   req_name_word1 = '0;
   logic [WORD_W-1:0]   req_name_word2 = '0;
   logic [WORD_W-1:0]   req_name_word3 = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_endpoint_slot;
   logic                csr_wr_en = 1'b0;
   logic [SLOT_W-1:0]   csr_wr_data = '0;

   name_type          names_held [MAX_ENTRIES];
   logic [5:0]        lengths_held [MAX_ENTRIES];
   int                entries_held = 0;
   logic [SLOT_W-1:0] slot_base_held = SLOT_BASE_RST;

   reply_type pending_replies [$];
   int        status_tally [8];
   int        items_sent = 0;
   int        base_settings = 0;
   int        errors = 0;
   int        idle_cycles = 0;
   bit        steady = 1'b0;

   name_registry_table #(
      .MAX_ENTRIES   (MAX_ENTRIES),
      .MAX_NAME_BYTES(MAX_NAME_BYTES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_name_length  (req_name_length),
      .req_name_word0   (req_name_word0),
      .req_name_word1   (req_name_word1),
      .req_name_word2   (req_name_word2),
      .req_name_word3   (req_name_word3),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_endpoint_slot(rsp_endpoint_slot),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic bit idle_roll();
      return !steady && ($urandom_range(99) < IDLE_PCT);
   endfunction

   function automatic name_type byte_mask(int nbytes);
      name_type m = '0;
      for (int i = 0; i < nbytes; i++) begin
         m[8*i +: 8] = 8'hFF;
      end
      return m;
   endfunction

   function automatic name_type random_name();
      name_type n;
      for (int i = 0; i < 8*MAX_NAME_BYTES/32; i++) begin
         n[32*i +: 32] = $urandom;
      end
      return n;
   endfunction

   function automatic int find_name(name_type key, int len);
      for (int i = 0; i < entries_held; i++) begin
         if (lengths_held[i] == len && names_held[i] == key) begin
            return i;
         end
      end
      return entries_held;
   endfunction

   // Update the table copy and return the reply one item produces.
   function automatic reply_type resolve_request(logic [OP_W-1:0] op,
                                                 logic [IN_LEN_W-1:0] len_in,
                                                 name_type name);
      int        len;
      int        hit;
      name_type  key;
      reply_type r;
      len = (len_in > MAX_NAME_BYTES) ? MAX_NAME_BYTES : int'(len_in);
      key = name & byte_mask(len);
      hit = find_name(key, len);
      r.slot = '0;
      if (op == OP_REGISTER) begin
         if (len == 0) begin
            r.status = STS_BAD_ARG;
         end else if (hit < entries_held) begin
            r.status = STS_EXISTS;
         end else if (entries_held >= MAX_ENTRIES) begin
            r.status = STS_FULL;
         end else begin
            names_held[entries_held]   = key;
            lengths_held[entries_held] = len[5:0];
            entries_held++;
            r.status = STS_OK;
         end
      end else if (op == OP_LOOKUP) begin
         if (len == 0) begin
            r.status = STS_BAD_ARG;
         end else if (hit < entries_held) begin
            r.status = STS_OK;
            r.slot   = slot_base_held + hit[SLOT_W-1:0];
         end else begin
            r.status = STS_NOT_FOUND;
         end
      end else begin
         r.status = STS_BAD_OP;
      end
      return r;
   endfunction

   function automatic void note_mismatch(string field, int want, int got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [IN_LEN_W-1:0] len_in,
                               input name_type name);
      reply_type r;
      @(negedge clock);
      while (idle_roll()) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_opcode      = op;
      req_name_length = len_in;
      req_name_word0  = name[63:0];
      req_name_word1  = name[127:64];
      req_name_word2  = name[191:128];
      req_name_word3  = name[255:192];
      req_valid       = 1'b1;
      do @(posedge clock); while (!req_ready);
      r = resolve_request(op, len_in, name);
      pending_replies.push_back(r);
      status_tally[r.status]++;
      items_sent++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_slot_base(input logic [SLOT_W-1:0] value);
      hold_until_drained();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      slot_base_held = value;
      base_settings++;
   endtask

   task automatic test_empty_and_bad_op();
      send_request(OP_REGISTER, 8'd0, '1);
      send_request(OP_LOOKUP, 8'd0, random_name());
      send_request(OP_UNUSED_LO, 8'd255, '1);
      send_request(OP_UNUSED_HI, 8'd5, '0);
      send_request(OP_LOOKUP, 8'd1, name_type'(8'h61));
   endtask

   task automatic test_register_lookup();
      send_request(OP_REGISTER, 8'd1, '1);
      send_request(OP_REGISTER, 8'd32, '1);
      send_request(OP_REGISTER, 8'd255, '1);
      send_request(OP_REGISTER, 8'd8, '0);
      send_request(OP_REGISTER, 8'd33, random_name());
      send_request(OP_LOOKUP, 8'd1, random_name() | name_type'(8'hFF));
      send_request(OP_LOOKUP, 8'd200, '1);
      send_request(OP_LOOKUP, 8'd31, '1);
      send_request(OP_LOOKUP, 8'd8, random_name() & ~byte_mask(8));
      send_request(OP_REGISTER, 8'd1, name_type'(8'hFF));
   endtask

   task automatic test_slot_base();
      write_slot_base(12'd0);
      send_request(OP_LOOKUP, 8'd32, '1);
      write_slot_base(12'd4095);
      send_request(OP_LOOKUP, 8'd1, name_type'(8'hFF));
      send_request(OP_LOOKUP, 8'd32, '1);
   endtask

   task automatic test_random_traffic(input int count, input bit hold_mid);
      int                  pick;
      int                  idx;
      int                  len;
      int                  bitpos;
      name_type            name;
      logic [OP_W-1:0]     op;
      logic [IN_LEN_W-1:0] len_in;
      for (int n = 0; n < count; n++) begin
         pick   = $urandom_range(99);
         name   = random_name();
         op     = OP_LOOKUP;
         len_in = IN_LEN_W'($urandom_range(MAX_NAME_BYTES, 1));
         idx    = (entries_held > 0) ? int'($urandom_range(entries_held - 1)) : 0;
         if (entries_held == 0 && pick < 72) begin
            pick = 0;
         end
         if (pick < 6) begin
            op = OP_REGISTER;
            if ($urandom_range(9) == 0) begin
               len_in = IN_LEN_W'($urandom_range(255, MAX_NAME_BYTES + 1));
            end
         end else if (pick < 72) begin
            len    = int'(lengths_held[idx]);
            name   = names_held[idx] | (name & ~byte_mask(len));
            len_in = IN_LEN_W'(len);
            if (len == MAX_NAME_BYTES && $urandom_range(1)) begin
               len_in = IN_LEN_W'($urandom_range(255, MAX_NAME_BYTES + 1));
            end
            op = (pick < 14) ? OP_REGISTER : OP_LOOKUP;
            if (pick >= 60) begin
               if ($urandom_range(1)) begin
                  bitpos = $urandom_range(8*len - 1);
                  name[bitpos] = ~name[bitpos];
               end else begin
                  len_in = IN_LEN_W'((len == MAX_NAME_BYTES) ? len - 1 : len + 1);
               end
            end
         end else if (pick < 80) begin
            op = OP_LOOKUP;
         end else if (pick < 86) begin
            op     = $urandom_range(1) ? OP_REGISTER : OP_LOOKUP;
            len_in = 8'd0;
         end else if (pick < 92) begin
            op     = $urandom_range(1) ? OP_UNUSED_LO : OP_UNUSED_HI;
            len_in = IN_LEN_W'($urandom_range(255));
         end else begin
            op     = OP_W'($urandom_range(3));
            len_in = IN_LEN_W'($urandom_range(255));
         end
         send_request(op, len_in, name);
         if (hold_mid && n == count/2) begin
            hold_until_drained();
         end
      end
   endtask

   task automatic test_full_table();
      while (entries_held < MAX_ENTRIES) begin
         send_request(OP_REGISTER, IN_LEN_W'($urandom_range(MAX_NAME_BYTES, 1)),
                      random_name());
      end
      send_request(OP_REGISTER, 8'd20, random_name());
      send_request(OP_REGISTER, IN_LEN_W'(lengths_held[MAX_ENTRIES-1]),
                   names_held[MAX_ENTRIES-1]);
      write_slot_base(12'd4080);
      send_request(OP_LOOKUP, IN_LEN_W'(lengths_held[MAX_ENTRIES-1]),
                   names_held[MAX_ENTRIES-1]);
      send_request(OP_LOOKUP, IN_LEN_W'(lengths_held[0]), names_held[0]);
   endtask

   always @(negedge clock) begin
      rsp_ready = !idle_roll();
   end

   always @(posedge clock) begin : check_replies
      reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual status %0d slot %0d",
                     $time, rsp_status, rsp_endpoint_slot);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status) begin
               note_mismatch("status", int'(want.status), int'(rsp_status));
            end
            if (rsp_endpoint_slot !== want.slot) begin
               note_mismatch("endpoint_slot", int'(want.slot), int'(rsp_endpoint_slot));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("tb_name_registry_table: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [SLOT_W-1:0] base;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_and_bad_op();
      test_register_lookup();
      test_slot_base();

      for (int p = 0; p < PHASES; p++) begin
         unique case (p)
            0: base = SLOT_BASE_RST;
            2: base = 12'd4070;
            3: base = 12'd0;
            default: base = SLOT_W'($urandom_range(4095));
         endcase
         write_slot_base(base);
         steady = (p == 2);
         test_random_traffic(PHASE_ITEMS, p == 1);
      end
      steady = 1'b0;

      test_full_table();

      hold_until_drained();
      repeat (MAX_ENTRIES + 8) @(posedge clock);

      $display("Covered %0d items over %0d slot base settings, table filled to %0d entries",
               items_sent, base_settings, entries_held);
      $display("Replies: ok %0d, bad argument %0d, exists %0d, full %0d, not found %0d, bad op %0d",
               status_tally[STS_OK], status_tally[STS_BAD_ARG], status_tally[STS_EXISTS],
               status_tally[STS_FULL], status_tally[STS_NOT_FOUND], status_tally[STS_BAD_OP]);
      if (errors == 0) begin
         $display("tb_name_registry_table: PASS");
      end else begin
         $display("tb_name_registry_table: FAIL");
      end
      $finish;
   end

endmodule
